FILE: rtl/core/drpt_pkg.sv
// Package for the recent-pair table: request codes, field widths and the
// command/status structs shared by the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package drpt_pkg;

    localparam int KIND_W  = 8;
    localparam int LEVEL_W = 4;
    localparam int REQ_W   = 2;
    localparam int SLOT_W  = 6;
    localparam int ENTRY_W = KIND_W + LEVEL_W;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_LOOKUP = 2'd2;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic scan_end;
        logic shift_start;
        logic shift_run;
        logic commit_rm;
        logic write_ins;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic             scan_done;
        logic             scan_hit;
        logic             shift_done;
        logic             out_ready;
        logic [REQ_W-1:0] req;
    } t_sts;

endpackage

`default_nettype wire

FILE: rtl/core/drpt_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module drpt_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/drpt_ctrl.sv
// Sequencing controller for the recent-pair table: accept, scan, shift or write,
// post the result. Depends on drpt_pkg.
`timescale 1ns / 1ps
`default_nettype none

module drpt_ctrl import drpt_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire t_sts i_sts,
    output      t_cmd o_cmd,
    output      logic o_in_stall
);

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_SHIFT = 5'b00100,
        ST_WRITE = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    t_cmd   cmd;

    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    cmd.load = 1'b1;
                    n_state  = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_sts.scan_done) begin
                    cmd.scan_run = 1'b1;
                end else begin
                    cmd.scan_end = 1'b1;
                    if (i_sts.scan_hit && i_sts.req == REQ_REMOVE) begin
                        cmd.shift_start = 1'b1;
                        n_state         = ST_SHIFT;
                    end else if (!i_sts.scan_hit && i_sts.req == REQ_INSERT) begin
                        n_state = ST_WRITE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SHIFT: begin
                if (!i_sts.shift_done) begin
                    cmd.shift_run = 1'b1;
                end else begin
                    cmd.commit_rm = 1'b1;
                    n_state       = ST_DONE;
                end
            end
            ST_WRITE: begin
                cmd.write_ins = 1'b1;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                if (i_sts.out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd      = cmd;
    assign o_in_stall = (r_state != ST_IDLE);

endmodule

`default_nettype wire

FILE: rtl/core/drpt_dpath.sv
// Datapath for the recent-pair table: request latch, pair store, scan and shift
// address counters, fill count, replacement pointer, result register.
// Depends on drpt_pkg and drpt_ram.
`timescale 1ns / 1ps
`default_nettype none

module drpt_dpath import drpt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output      t_sts               o_sts,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [LEVEL_W-1:0] i_level,
    input  wire logic               i_out_stall,
    output      logic               o_out_valid,
    output      logic               o_ok,
    output      logic               o_found,
    output      logic [SLOT_W-1:0]  o_slot
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [REQ_W-1:0]   r_req;
    logic [ENTRY_W-1:0] r_pair;
    logic [CW-1:0]      r_fill;
    logic [IW-1:0]      r_rptr;
    logic [IW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_rd_left;
    logic               r_cmp_vld;
    logic [IW-1:0]      r_cmp_idx;
    logic               r_hit;
    logic [IW-1:0]      r_hit_idx;
    logic [IW-1:0]      r_wslot;
    logic               r_out_vld;
    logic               r_ok;
    logic               r_found;
    logic [SLOT_W-1:0]  r_slot;

    logic [ENTRY_W-1:0] rd_data;
    logic               rd_en;
    logic               hit_now;
    logic               full;
    logic [IW-1:0]      ins_slot;
    logic [CW-1:0]      fill_m1;
    logic [IW-1:0]      cmp_idx_p1;
    logic               ram_we;
    logic [IW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               res_ok;
    logic               res_found;
    logic [IW-1:0]      res_idx;
    logic [SLOT_W+IW-1:0] res_ext;

    drpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_rd_idx),
        .o_rdata (rd_data)
    );

    assign rd_en      = (i_cmd.scan_run || i_cmd.shift_run) && (r_rd_left != '0);
    assign hit_now    = r_cmp_vld && (rd_data == r_pair);
    assign full       = (r_fill == CW'(TABLE_DEPTH));
    assign ins_slot   = full ? r_rptr : r_fill[IW-1:0];
    assign fill_m1    = r_fill - CW'(1);
    assign cmp_idx_p1 = r_cmp_idx + IW'(1);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = ins_slot;
        ram_wdata = r_pair;
        if (i_cmd.write_ins) begin
            ram_we = 1'b1;
        end else if (i_cmd.shift_run && r_cmp_vld) begin
            ram_we    = 1'b1;
            ram_waddr = r_cmp_idx - IW'(1);
            ram_wdata = rd_data;
        end
    end

    assign res_ok    = (r_req == REQ_INSERT) ? !r_hit
                     : ((r_req == REQ_REMOVE || r_req == REQ_LOOKUP) && r_hit);
    assign res_found = r_hit && (r_req == REQ_INSERT || r_req == REQ_REMOVE ||
                                 r_req == REQ_LOOKUP);
    always_comb begin
        res_idx = '0;
        if (r_req == REQ_INSERT && !r_hit) begin
            res_idx = r_wslot;
        end else if (res_found) begin
            res_idx = r_hit_idx;
        end
    end
    assign res_ext = {{SLOT_W{1'b0}}, res_idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_rptr    <= '0;
            r_cmp_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_cmp_vld <= rd_en;
            if (i_cmd.write_ins) begin
                if (full) begin
                    r_rptr <= (r_rptr == IW'(TABLE_DEPTH - 1)) ? '0 : r_rptr + IW'(1);
                end else begin
                    r_fill <= r_fill + CW'(1);
                end
            end
            if (i_cmd.commit_rm) begin
                if (r_rptr != '0) begin
                    r_rptr <= r_rptr - IW'(1);
                end
                if (r_fill != '0) begin
                    r_fill <= fill_m1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req     <= i_req_type;
            r_pair    <= {i_kind, i_level};
            r_rd_idx  <= fill_m1[IW-1:0];
            r_rd_left <= r_fill;
        end else if (i_cmd.shift_start) begin
            r_rd_idx  <= cmp_idx_p1;
            r_rd_left <= fill_m1 - CW'(r_cmp_idx);
        end else if (rd_en) begin
            r_rd_idx  <= i_cmd.shift_run ? r_rd_idx + IW'(1) : r_rd_idx - IW'(1);
            r_rd_left <= r_rd_left - CW'(1);
        end
        r_cmp_idx <= r_rd_idx;
        if (i_cmd.load) begin
            r_hit <= 1'b0;
        end else if (i_cmd.scan_end) begin
            r_hit     <= hit_now;
            r_hit_idx <= r_cmp_idx;
        end
        if (i_cmd.write_ins) begin
            r_wslot <= ins_slot;
        end
        if (i_cmd.out_load) begin
            r_ok    <= res_ok;
            r_found <= res_found;
            r_slot  <= res_ext[SLOT_W-1:0];
        end
    end

    assign o_sts.scan_done  = hit_now || (r_rd_left == '0 && !r_cmp_vld);
    assign o_sts.scan_hit   = hit_now;
    assign o_sts.shift_done = (r_rd_left == '0) && !r_cmp_vld;
    assign o_sts.out_ready  = !r_out_vld || !i_out_stall;
    assign o_sts.req        = r_req;

    assign o_out_valid = r_out_vld;
    assign o_ok        = r_ok;
    assign o_found     = r_found;
    assign o_slot      = r_slot;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH))
        else $error("fill count beyond table depth");

    a_rptr_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rptr <= IW'(TABLE_DEPTH - 1))
        else $error("replacement pointer beyond table depth");

    a_no_write_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.scan_run |-> !ram_we)
        else $error("store written during search");

    a_remove_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit_rm |-> (r_fill != '0 && r_hit))
        else $error("remove committed without a matched entry");

endmodule

`default_nettype wire

FILE: rtl/core/dedup_recent_pair_table.sv
// Recent-pair table: one transaction in, one result out; no overlap between requests.
// Steps: accept, search the filled slots newest first, then write an insert that missed or shift
// the later slots down for a remove that hit, then post the result. A new request is taken only
// once the previous result is posted; the single store read port paces search and shift.
// Reset: fill count and replacement pointer cleared; stale slots above the fill count
// are never read, so the store needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module dedup_recent_pair_table import drpt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output      logic               o_in_stall,
    input  wire logic [REQ_W-1:0]   i_req_type,
    input  wire logic [KIND_W-1:0]  i_kind,
    input  wire logic [LEVEL_W-1:0] i_level,
    output      logic               o_out_valid,
    input  wire logic               i_out_stall,
    output      logic               o_ok,
    output      logic               o_found,
    output      logic [SLOT_W-1:0]  o_slot
);

    t_cmd cmd;
    t_sts sts;

    drpt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    drpt_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_req_type  (i_req_type),
        .i_kind      (i_kind),
        .i_level     (i_level),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_ok        (o_ok),
        .o_found     (o_found),
        .o_slot      (o_slot)
    );

endmodule

`default_nettype wire

FILE: verif/drpt_checker.sv
// Checker for the recent-pair table: watches both channels, predicts each result
// from its own copy of the table and compares it field by field. Needs drpt_pkg.
`timescale 1ns / 1ps

module drpt_checker import drpt_pkg::*; #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  logic [REQ_W-1:0]   i_req_type,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic               i_ok,
    input  logic               i_found,
    input  logic [SLOT_W-1:0]  i_slot,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic              ok;
        logic              found;
        logic [SLOT_W-1:0] slot;
    } t_table_reply;

    logic [KIND_W-1:0]  kind_mem [TABLE_DEPTH];
    logic [LEVEL_W-1:0] level_mem [TABLE_DEPTH];
    int                 fill_cnt;
    int                 repl_ptr;
    t_table_reply       reply_q[$];
    int                 fail_total = 0;
    int                 pending_total = 0;

    assign o_fail_count = fail_total;
    assign o_pending    = pending_total;

    task automatic note_failure(input string what, input t_table_reply want,
                                input t_table_reply got);
        fail_total++;
        if (fail_total <= 10) begin
            $display("%0t: %s: expected ok=%0b found=%0b slot=%0d, got ok=%0b found=%0b slot=%0d",
                     $time, what, want.ok, want.found, want.slot, got.ok, got.found, got.slot);
        end
    endtask

    task automatic apply_pair_request(input logic [REQ_W-1:0] rq, input logic [KIND_W-1:0] k,
                                      input logic [LEVEL_W-1:0] lv, output t_table_reply r);
        int hit;
        int wr;
        hit = -1;
        r   = '0;
        for (int n = fill_cnt - 1; n >= 0; n--) begin
            if (hit < 0 && kind_mem[n] == k && level_mem[n] == lv) begin
                hit = n;
            end
        end
        case (rq)
            REQ_INSERT: begin
                if (hit >= 0) begin
                    r.found = 1'b1;
                    r.slot  = hit[SLOT_W-1:0];
                end else begin
                    if (fill_cnt < TABLE_DEPTH) begin
                        wr = fill_cnt;
                        fill_cnt++;
                    end else begin
                        wr = repl_ptr % TABLE_DEPTH;
                        repl_ptr = (wr + 1 >= TABLE_DEPTH) ? 0 : wr + 1;
                    end
                    kind_mem[wr]  = k;
                    level_mem[wr] = lv;
                    r.ok   = 1'b1;
                    r.slot = wr[SLOT_W-1:0];
                end
            end
            REQ_REMOVE: begin
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < TABLE_DEPTH; i++) begin
                        kind_mem[i]  = kind_mem[i+1];
                        level_mem[i] = level_mem[i+1];
                    end
                    kind_mem[TABLE_DEPTH-1]  = '0;
                    level_mem[TABLE_DEPTH-1] = '0;
                    if (repl_ptr > 0) repl_ptr--;
                    if (fill_cnt > 0) fill_cnt--;
                    r.ok    = 1'b1;
                    r.found = 1'b1;
                    r.slot  = hit[SLOT_W-1:0];
                end
            end
            REQ_LOOKUP: begin
                if (hit >= 0) begin
                    r.ok    = 1'b1;
                    r.found = 1'b1;
                    r.slot  = hit[SLOT_W-1:0];
                end
            end
            default: begin
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_table_reply want;
        t_table_reply got;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                kind_mem[i]  = '0;
                level_mem[i] = '0;
            end
            fill_cnt = 0;
            repl_ptr = 0;
            reply_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                got = '{ok: i_ok, found: i_found, slot: i_slot};
                if (reply_q.size() == 0) begin
                    note_failure("result with nothing outstanding", '0, got);
                end else begin
                    want = reply_q.pop_front();
                    if (want.ok !== got.ok || want.found !== got.found
                            || want.slot !== got.slot) begin
                        note_failure("result mismatch", want, got);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                apply_pair_request(i_req_type, i_kind, i_level, want);
                reply_q.push_back(want);
            end
        end
        pending_total = reply_q.size();
    end

endmodule

FILE: verif/tb_dedup_recent_pair_table.sv
// Top of the recent-pair table testbench: clock, reset, request and result traffic,
// and the verdict. Needs drpt_pkg, dedup_recent_pair_table and drpt_checker.
`timescale 1ns / 1ps

module tb_dedup_recent_pair_table import drpt_pkg::*;;

    localparam int                 TABLE_DEPTH  = 64;
    localparam int                 POOL_N       = 96;
    localparam int                 SEG_ITEMS    = 170;
    localparam int                 HOLD_AT      = 500;
    localparam int                 HOLD_CYCLES  = 600;
    localparam int                 DRAIN_CYCLES = 2 * TABLE_DEPTH + 16;
    localparam logic [REQ_W-1:0]   REQ_UNUSED   = 2'd3;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [REQ_W-1:0]   req_type = REQ_LOOKUP;
    logic [KIND_W-1:0]  kind = '0;
    logic [LEVEL_W-1:0] level = '0;
    logic               out_stall = 1'b0;
    logic               in_stall;
    logic               out_valid;
    logic               ok;
    logic               found;
    logic [SLOT_W-1:0]  slot;
    int                 fail_count;
    int                 pending;

    logic [KIND_W-1:0]  pool_kind [POOL_N];
    logic [LEVEL_W-1:0] pool_level [POOL_N];
    logic               tx_calm = 1'b0;
    int                 rx_done = 0;

    always #10 i_clk = ~i_clk;

    dedup_recent_pair_table #(.TABLE_DEPTH(TABLE_DEPTH)) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_req_type  (req_type),
        .i_kind      (kind),
        .i_level     (level),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_ok        (ok),
        .o_found     (found),
        .o_slot      (slot)
    );

    drpt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_req_type   (req_type),
        .i_kind       (kind),
        .i_level      (level),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_ok         (ok),
        .i_found      (found),
        .i_slot       (slot),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic send_request(input logic [REQ_W-1:0] rq, input logic [KIND_W-1:0] k,
                                input logic [LEVEL_W-1:0] lv);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid = 1'b1;
        req_type = rq;
        kind     = k;
        level    = lv;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
    endtask

    task automatic random_request(input int ins_pct, input int rem_pct);
        logic [REQ_W-1:0]   rq;
        logic [KIND_W-1:0]  k;
        logic [LEVEL_W-1:0] lv;
        int                 roll;
        int                 idx;
        roll = $urandom_range(0, 99);
        if (roll < 4) rq = REQ_UNUSED;
        else if (roll < 4 + ins_pct) rq = REQ_INSERT;
        else if (roll < 4 + ins_pct + rem_pct) rq = REQ_REMOVE;
        else rq = REQ_LOOKUP;
        idx = $urandom_range(0, POOL_N - 1);
        if ($urandom_range(0, 99) < 65) begin
            k  = pool_kind[idx];
            lv = pool_level[idx];
        end else begin
            k  = KIND_W'($urandom_range(0, 255));
            lv = LEVEL_W'($urandom_range(0, 15));
            if (rq == REQ_INSERT) begin
                pool_kind[idx]  = k;
                pool_level[idx] = lv;
            end
        end
        send_request(rq, k, lv);
    endtask

    task automatic drain_table_replies();
        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // result side: random stall per transaction, a calm stretch and one long hold-off
    initial begin
        int wait_cycles;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_done == HOLD_AT) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            wait_cycles = (rx_done >= 150 && rx_done < 300) ? 0 : $urandom_range(0, 6);
            if (wait_cycles > 0) begin
                out_stall = 1'b1;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (!out_valid);
            rx_done++;
            @(negedge i_clk);
        end
    end

    initial begin
        int ins_pct;
        int rem_pct;
        for (int i = 0; i < POOL_N; i++) begin
            pool_kind[i]  = KIND_W'($urandom_range(0, 255));
            pool_level[i] = LEVEL_W'($urandom_range(0, 15));
        end
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        send_request(REQ_LOOKUP, 8'd0, 4'd0);
        send_request(REQ_REMOVE, 8'd0, 4'd0);
        send_request(REQ_INSERT, 8'd0, 4'd0);
        send_request(REQ_INSERT, 8'd0, 4'd0);
        send_request(REQ_INSERT, 8'd255, 4'd15);
        send_request(REQ_INSERT, 8'd255, 4'd0);
        send_request(REQ_INSERT, 8'd0, 4'd15);
        send_request(REQ_LOOKUP, 8'd255, 4'd15);
        send_request(REQ_UNUSED, 8'd255, 4'd15);
        send_request(REQ_REMOVE, 8'd255, 4'd15);
        send_request(REQ_LOOKUP, 8'd0, 4'd15);
        send_request(REQ_REMOVE, 8'd0, 4'd0);
        send_request(REQ_LOOKUP, 8'd0, 4'd0);
        send_request(REQ_INSERT, 8'd170, 4'd5);
        send_request(REQ_INSERT, 8'd85, 4'd10);
        send_request(REQ_REMOVE, 8'd85, 4'd10);
        drain_table_replies();

        for (int seg = 0; seg < 6; seg++) begin
            case (seg)
                0: begin ins_pct = 80; rem_pct = 4; end
                1: begin ins_pct = 45; rem_pct = 20; end
                2: begin ins_pct = 15; rem_pct = 55; end
                3: begin ins_pct = 70; rem_pct = 10; end
                4: begin ins_pct = 40; rem_pct = 30; end
                default: begin ins_pct = 85; rem_pct = 5; end
            endcase
            if (seg == 3) drain_table_replies();
            tx_calm = (seg == 2);
            repeat (SEG_ITEMS) random_request(ins_pct, rem_pct);
        end

        in_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("dedup_recent_pair_table verification clean");
        end else begin
            $display("dedup_recent_pair_table verification failed");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("dedup_recent_pair_table verification failed");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/drpt_pkg.sv
rtl/core/drpt_ram.sv
rtl/core/drpt_ctrl.sv
rtl/core/drpt_dpath.sv
rtl/core/dedup_recent_pair_table.sv
verif/drpt_checker.sv
verif/tb_dedup_recent_pair_table.sv
